@@ hdl/msgfrag_pkg.sv @@
// Shared types and constants for the message fragmenter.
// Used by every module in hdl/ but msgfrag_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msgfrag_pkg;

    // Fragment length field and payload store geometry
    localparam int LEN_W           = 6;
    localparam int STORE_DEPTH     = 1 << LEN_W;
    localparam int BANKS           = 2;
    localparam int PAYLOAD_MAX_DEF = 63;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Header byte bits
    localparam int LAST_POS  = 7;
    localparam int FIRST_POS = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_fragment;
    } out_item_t;

    // One closed fragment waiting for the back end
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             first;
        logic             last;
    } frag_desc_t;

    // Back end hands a payload bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    // Front end status, for checks at the top level
    typedef struct packed {
        logic [BANKS-1:0] busy;
        logic             wr_bank;
    } front_status_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_SEND
    } back_state_t;

endpackage

`default_nettype wire

@@ hdl/msgfrag_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msgfrag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/msgfrag_front.sv @@
// Front end: takes input items, fills the payload banks, closes fragments.
// Depends on msgfrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msgfrag_front #(
    parameter int PAYLOAD_MAX = msgfrag_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire msgfrag_pkg::in_item_t                 item,
    output logic                                       ram_we,
    output logic [msgfrag_pkg::LEN_W:0]                ram_waddr,
    output logic [7:0]                                 ram_wdata,
    output logic                                       push,
    output msgfrag_pkg::frag_desc_t                    push_desc,
    input  wire msgfrag_pkg::bank_release_t            release_bank,
    output msgfrag_pkg::front_status_t                 status
);

    localparam int LEN_W = msgfrag_pkg::LEN_W;

    logic [LEN_W-1:0]              fill_reg, fill_next;
    logic                          start_reg, start_next;
    logic                          wr_bank_reg, wr_bank_next;
    logic [msgfrag_pkg::BANKS-1:0] busy_reg, busy_next;

    logic             accept;
    logic             take_byte;
    logic [LEN_W-1:0] new_fill;
    logic             close_frag;

    // Stall while the bank being filled is still owned by the back end
    assign item_stall = busy_reg[wr_bank_reg];
    assign accept     = item_valid && !item_stall;

    // Buffer the byte, then decide whether the fragment closes
    always_comb
    begin
        take_byte  = accept && item.has_byte && (fill_reg < LEN_W'(PAYLOAD_MAX));
        new_fill   = take_byte ? fill_reg + 1'b1 : fill_reg;
        close_frag = accept && (item.end_of_message || (new_fill >= LEN_W'(PAYLOAD_MAX)));

        ram_we    = take_byte;
        ram_waddr = {wr_bank_reg, fill_reg};
        ram_wdata = item.data_byte;

        push            = close_frag;
        push_desc.bank  = wr_bank_reg;
        push_desc.len   = new_fill;
        push_desc.first = start_reg;
        push_desc.last  = item.end_of_message;

        fill_next    = new_fill;
        start_next   = start_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        if (release_bank.valid)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end
        if (close_frag)
        begin
            fill_next              = '0;
            start_next             = item.end_of_message;
            wr_bank_next           = ~wr_bank_reg;
            busy_next[wr_bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            start_reg   <= 1'b1;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            start_reg   <= start_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

    assign status.busy    = busy_reg;
    assign status.wr_bank = wr_bank_reg;

endmodule

`default_nettype wire

@@ hdl/msgfrag_queue.sv @@
// Small FIFO of fragment descriptors between front and back ends.
// Depends on msgfrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msgfrag_queue #(
    parameter int DEPTH = msgfrag_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire msgfrag_pkg::frag_desc_t push_desc,
    input  wire logic                    pop,
    output msgfrag_pkg::frag_desc_t      head,
    output logic                         empty,
    output logic                         full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msgfrag_pkg::frag_desc_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = entries[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

@@ hdl/msgfrag_back.sv @@
// Back end: sends the header, then streams payload bytes out of the RAM.
// Depends on msgfrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msgfrag_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire msgfrag_pkg::frag_desc_t      head,
    input  wire logic                         empty,
    output logic                              pop,
    output logic                              ram_re,
    output logic [msgfrag_pkg::LEN_W:0]       ram_raddr,
    input  wire logic [7:0]                   ram_rdata,
    output msgfrag_pkg::bank_release_t        release_bank,
    output logic                              frag_valid,
    input  wire logic                         frag_stall,
    output msgfrag_pkg::out_item_t            frag
);

    localparam int LEN_W = msgfrag_pkg::LEN_W;

    msgfrag_pkg::back_state_t state_reg, state_next;
    msgfrag_pkg::frag_desc_t  cur_reg, cur_next;
    logic [LEN_W-1:0]         idx_reg, idx_next;
    logic                     out_valid_reg, out_valid_next;
    msgfrag_pkg::out_item_t   out_reg, out_next;

    logic             load_ok;
    logic [LEN_W-1:0] idx_inc;

    assign load_ok = !out_valid_reg || !frag_stall;
    assign idx_inc = idx_reg + 1'b1;

    // Sequencer: queue head header, then one byte per cycle while not stalled
    always_comb
    begin
        state_next         = state_reg;
        cur_next           = cur_reg;
        idx_next           = idx_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && frag_stall;
        pop                = 1'b0;
        ram_re             = 1'b0;
        ram_raddr          = {cur_reg.bank, idx_inc};
        release_bank.valid = 1'b0;
        release_bank.bank  = cur_reg.bank;

        case (state_reg)
            msgfrag_pkg::BK_IDLE:
            begin
                if (!empty && load_ok)
                begin
                    pop            = 1'b1;
                    cur_next       = head;
                    out_valid_next = 1'b1;
                    out_next.out_byte = {head.last, head.first, head.len};
                    out_next.end_of_fragment = (head.len == '0);
                    if (head.len == '0)
                    begin
                        release_bank.valid = 1'b1;
                        release_bank.bank  = head.bank;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = {head.bank, {LEN_W{1'b0}}};
                        idx_next   = '0;
                        state_next = msgfrag_pkg::BK_SEND;
                    end
                end
            end
            msgfrag_pkg::BK_SEND:
            begin
                if (load_ok)
                begin
                    out_valid_next           = 1'b1;
                    out_next.out_byte        = ram_rdata;
                    out_next.end_of_fragment = (idx_inc == cur_reg.len);
                    if (idx_inc == cur_reg.len)
                    begin
                        release_bank.valid = 1'b1;
                        state_next         = msgfrag_pkg::BK_IDLE;
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = msgfrag_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msgfrag_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    assign frag_valid = out_valid_reg;
    assign frag       = out_reg;

endmodule

`default_nettype wire

@@ hdl/message_fragmenter_top.sv @@
// Message fragmenter: one input item per cycle while a payload bank is free.
// Headers pass through the descriptor queue, then the output register;
// payload bytes follow at one per cycle from the RAM unless frag_stall.
// Two payload banks: the front stalls only when both banks await the back.
// Reset clears control state only; payload RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module message_fragmenter_top #(
    parameter int PAYLOAD_MAX = msgfrag_pkg::PAYLOAD_MAX_DEF,
    parameter int QUEUE_DEPTH = msgfrag_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire msgfrag_pkg::in_item_t  item,
    output logic                        frag_valid,
    input  wire logic                   frag_stall,
    output msgfrag_pkg::out_item_t      frag
);

    localparam int LEN_W     = msgfrag_pkg::LEN_W;
    localparam int RAM_DEPTH = msgfrag_pkg::BANKS * msgfrag_pkg::STORE_DEPTH;

    logic                          ram_we;
    logic [LEN_W:0]                ram_waddr;
    logic [7:0]                    ram_wdata;
    logic                          ram_re;
    logic [LEN_W:0]                ram_raddr;
    logic [7:0]                    ram_rdata;
    logic                          push;
    logic                          pop;
    logic                          q_empty;
    logic                          q_full;
    msgfrag_pkg::frag_desc_t       push_desc;
    msgfrag_pkg::frag_desc_t       q_head;
    msgfrag_pkg::bank_release_t    release_bank;
    msgfrag_pkg::front_status_t    front_status;

    msgfrag_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .push         (push),
        .push_desc    (push_desc),
        .release_bank (release_bank),
        .status       (front_status)
    );

    msgfrag_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msgfrag_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    msgfrag_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .release_bank (release_bank),
        .frag_valid   (frag_valid),
        .frag_stall   (frag_stall),
        .frag         (frag)
    );

    // Descriptor queue never overflows nor underflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_full || pop))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("descriptor queue underflow");

    // Front never writes into a bank still owned by the back end
    a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !front_status.busy[ram_waddr[LEN_W]])
        else $error("payload write into busy bank");

    // Only a busy bank is handed back
    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        release_bank.valid |-> front_status.busy[release_bank.bank])
        else $error("release of idle bank");

endmodule

`default_nettype wire

@@ bench/frag_checker.sv @@
`timescale 1ns / 1ps
// Fragment checker: watches both channels of the message fragmenter, predicts
// the header and payload bytes of every fragment and compares them in order.
// Depends on msgfrag_pkg for the item types and header bit positions.

module frag_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  msgfrag_pkg::in_item_t  item,
    input  logic                   frag_valid,
    input  logic                   frag_stall,
    input  msgfrag_pkg::out_item_t frag,
    output int                     mismatches,
    output int                     bytes_owed
);

    import msgfrag_pkg::*;

    localparam int FRAG_MAX = PAYLOAD_MAX_DEF;

    // Shadow of the fragmenter: buffered payload, fill level, first-fragment flag
    logic [7:0] held_bytes [FRAG_MAX];
    int         held_count;
    logic       opens_message;

    // Output bytes still owed by the block, oldest first
    out_item_t  owed_bytes [$];
    out_item_t  want;
    int         fail_tally;

    // Buffer one input item; close a fragment on end of message or full buffer
    task automatic predict_fragment(input in_item_t it);
        out_item_t b;
        int        k;
        if (it.has_byte && held_count < FRAG_MAX)
        begin
            held_bytes[held_count] = it.data_byte;
            held_count++;
        end
        if (it.end_of_message || held_count >= FRAG_MAX)
        begin
            b.out_byte                = '0;
            b.out_byte[LEN_W-1:0]     = held_count[LEN_W-1:0];
            b.out_byte[FIRST_POS]     = opens_message;
            b.out_byte[LAST_POS]      = it.end_of_message;
            b.end_of_fragment         = (held_count == 0);
            owed_bytes.push_back(b);
            for (k = 0; k < held_count; k++)
            begin
                b.out_byte        = held_bytes[k];
                b.end_of_fragment = (k == held_count - 1);
                owed_bytes.push_back(b);
            end
            held_count    = 0;
            opens_message = it.end_of_message;
        end
    endtask

    // Predict on accepted input, compare on accepted output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count    = 0;
            opens_message = 1'b1;
            fail_tally    = 0;
            owed_bytes.delete();
            mismatches <= 0;
            bytes_owed <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_fragment(item);
            if (frag_valid && !frag_stall)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("unexpected output item: out_byte %02h end_of_fragment %0b",
                           frag.out_byte, frag.end_of_fragment);
                    fail_tally++;
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (frag.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, frag.out_byte);
                        fail_tally++;
                    end
                    if (frag.end_of_fragment !== want.end_of_fragment)
                    begin
                        $error("end_of_fragment: expected %0b, actual %0b",
                               want.end_of_fragment, frag.end_of_fragment);
                        fail_tally++;
                    end
                end
            end
            mismatches <= fail_tally;
            bytes_owed <= owed_bytes.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the fragmenter bench: clock, reset, message stimulus with bursty
// sender and stalling receiver, watchdog and verdict.
// Depends on msgfrag_pkg, message_fragmenter_top and frag_checker.

module testbench;

    import msgfrag_pkg::*;

    localparam int MSG_ITEMS   = 360;
    localparam int HOLD_START  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_SLACK = 20;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item       = '0;
    logic      frag_valid;
    logic      frag_stall = 1'b0;
    out_item_t frag;

    int        mismatches;
    int        bytes_owed;
    int        quiet_cycles;

    in_item_t  msg_items [$];

    message_fragmenter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .frag_valid (frag_valid),
        .frag_stall (frag_stall),
        .frag       (frag)
    );

    frag_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .frag_valid (frag_valid),
        .frag_stall (frag_stall),
        .frag       (frag),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    // Clock and reset
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: too long with nothing moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (frag_valid && !frag_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic void add_item(logic [7:0] d, logic h, logic e);
        in_item_t it;
        it.data_byte      = d;
        it.has_byte       = h;
        it.end_of_message = e;
        msg_items.push_back(it);
    endfunction

    // Directed corners, then random messages with some noise between them
    function automatic void build_messages();
        int len;
        int k;
        bit tail_mark;
        // empty message, one-byte messages at the data extremes
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'hFF, 1'b1, 1'b1);
        // idle item and end mark alone, both with data that must be ignored
        add_item(8'hA5, 1'b0, 1'b0);
        add_item(8'h55, 1'b1, 1'b0);
        add_item(8'hAA, 1'b1, 1'b0);
        add_item(8'h3C, 1'b0, 1'b1);
        add_item(8'h01, 1'b1, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0);
        add_item(8'h80, 1'b1, 1'b1);
        add_item(8'hC3, 1'b0, 1'b1);
        while (msg_items.size() < MSG_ITEMS)
        begin
            k = $urandom_range(0, 99);
            if (k < 78)
            begin
                // well-formed message, mostly short, some around the buffer size
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    6, 7:    len = $urandom_range(61, 65);
                    8:       len = $urandom_range(124, 128);
                    9:       len = $urandom_range(13, 40);
                    default: len = $urandom_range(1, 12);
                endcase
                tail_mark = (len > 0) && ($urandom_range(0, 1) == 1);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    add_item(8'($urandom_range(0, 255)), 1'b1,
                             tail_mark && (k == len - 1));
                end
                if (!tail_mark)
                    add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            else
            begin
                // noise: random flags, runs into whatever comes next
                for (k = $urandom_range(1, 4); k > 0; k--)
                begin
                    add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) == 0);
                end
            end
        end
    endfunction

    // Sender: bursts of items with random gaps, then drain and verdict
    initial
    begin : sender
        int i;
        int burst;
        int gap;
        build_messages();
        wait (rst_n);
        @(posedge clk);
        i = 0;
        while (i < msg_items.size())
        begin
            burst = $urandom_range(1, 30);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && i < msg_items.size())
            begin
                item_valid <= 1'b1;
                item       <= msg_items[i];
                do
                    @(posedge clk);
                while (item_stall);
                i++;
                burst--;
            end
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: phases of differing stall density, one long hold-off early on
    int stall_cycles_run;

    task automatic stall_phase();
        int span;
        int mode;
        int n;
        span = $urandom_range(20, 120);
        mode = $urandom_range(0, 3);
        for (n = 0; n < span; n++)
        begin
            case (mode)
                0:       frag_stall <= 1'b0;
                1:       frag_stall <= ($urandom_range(0, 3) == 0);
                2:       frag_stall <= ($urandom_range(0, 3) != 0);
                default: frag_stall <= n[3];
            endcase
            @(posedge clk);
        end
        stall_cycles_run += span;
    endtask

    initial
    begin
        stall_cycles_run = 0;
        wait (rst_n);
        @(posedge clk);
        while (stall_cycles_run < HOLD_START)
            stall_phase();
        // long hold-off so the block fills both banks and stalls its input
        frag_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        forever
            stall_phase();
    end

endmodule
